### sv/assert_macros.svh
// Assertion macros for the RTL of the stopwatch and alarm timer bank.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds at a rising clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### sv/satb_pkg.sv
// Types, command codes and defaults of the stopwatch and alarm timer bank.
// Used by satb_unit and by the top level; depends on nothing.
package satb_pkg;

	localparam int SW_CHANNELS_DEF = 4;
	localparam int AL_CHANNELS_DEF = 4;
	localparam int MAX_CHANNELS    = 16;

	typedef enum logic [3:0] {
		FN_TICK      = 4'd0,
		FN_SW_START  = 4'd1,
		FN_SW_SET    = 4'd2,
		FN_SW_READ   = 4'd3,
		FN_AL_START  = 4'd4,
		FN_AL_MS     = 4'd5,
		FN_AL_READ   = 4'd6,
		FN_AL_SET    = 4'd7,
		FN_AL_TAKE   = 4'd8
	} func_t;

	// Channel state codes; code 3 may be stored and read back but does nothing.
	localparam logic [1:0] CS_IDLE     = 2'd0;
	localparam logic [1:0] CS_COUNTING = 2'd1;
	localparam logic [1:0] CS_FINISHED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SW,
		ST_AL,
		ST_CMD,
		ST_DONE
	} state_t;

	typedef enum logic [0:0] {
		OP_INC,
		OP_MUL100
	} unit_op_t;

	typedef struct packed {
		unit_op_t    op;
		logic [31:0] a;
		logic [31:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        eq;
	} unit_rsp_t;

endpackage

### sv/satb_unit.sv
// Shared arithmetic unit of the timer bank: increment, times-100 and equality.
// Depends on satb_pkg.
module satb_unit (
	input  satb_pkg::unit_req_t req,
	output satb_pkg::unit_rsp_t rsp
);
	import satb_pkg::*;

	always_comb begin
		unique case (req.op)
			OP_INC:    rsp.result = req.a + 32'd1;
			// 100 = 64 + 32 + 4, wrapping at 32 bits.
			OP_MUL100: rsp.result = (req.a << 6) + (req.a << 5) + (req.a << 2);
			default:   rsp.result = req.a;
		endcase
		rsp.eq = (req.a == req.b);
	end

endmodule

### sv/stopwatch_alarm_timer_bank_unit.sv
// Top level of the stopwatch and alarm timer bank; uses satb_pkg and satb_unit.
// Assertions come from assert_macros.svh.
`include "assert_macros.svh"

// A bank of stopwatch and alarm channels driven by one command request at a time on the
// slave stream. Every request gives exactly one result request on the master stream:
// tuser carries ok and tdata the 32-bit data. A command other than a tick is accepted,
// executed and handed over in turn, and its result is registered in the execute step
// before it is offered. A tick walks the channels through one shared incrementer and
// comparator, one channel per cycle, stopwatches first and then alarms, and then hands
// its result over; every result is offered as the block becomes ready again. The block
// accepts a new request only while no request is in work; a finished result may still
// wait in the output register meanwhile, and the block holds a later result until that
// register has been taken.
module stopwatch_alarm_timer_bank_unit #(
	parameter int STOPWATCH_CHANNELS = satb_pkg::SW_CHANNELS_DEF,
	parameter int ALARM_CHANNELS     = satb_pkg::AL_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [3:0] channel, [35:4] value, [39:36] zero
	input  logic [3:0]  s_tuser,   // [3:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data
	output logic [0:0]  m_tuser    // [0] ok
);
	import satb_pkg::*;

	localparam int SW_IW = (STOPWATCH_CHANNELS > 1) ? $clog2(STOPWATCH_CHANNELS) : 1;
	localparam int AL_IW = (ALARM_CHANNELS > 1) ? $clog2(ALARM_CHANNELS) : 1;
	localparam logic [4:0] SW_LIM  = 5'(STOPWATCH_CHANNELS);
	localparam logic [4:0] AL_LIM  = 5'(ALARM_CHANNELS);
	localparam logic [3:0] SW_LAST = 4'(STOPWATCH_CHANNELS - 1);
	localparam logic [3:0] AL_LAST = 4'(ALARM_CHANNELS - 1);

	// Channel storage. All entries are read at the single address idx_q.
	logic [31:0] sw_count_q [STOPWATCH_CHANNELS];
	logic [1:0]  sw_state_q [STOPWATCH_CHANNELS];
	logic [31:0] al_count_q [ALARM_CHANNELS];
	logic [31:0] al_limit_q [ALARM_CHANNELS];
	logic [1:0]  al_state_q [ALARM_CHANNELS];

	state_t      state_q, state_d;
	logic [3:0]  idx_q, idx_d;
	logic [3:0]  func_q;
	logic [3:0]  ch_q;
	logic [31:0] val_q;
	logic        res_ok_q, res_ok_d;
	logic [31:0] res_data_q, res_data_d;
	logic        m_valid_q;
	logic        m_ok_q;
	logic [31:0] m_data_q;

	logic [SW_IW-1:0] sw_a;
	logic [AL_IW-1:0] al_a;
	logic             sw_valid, al_valid;
	logic [1:0]       sw_st, al_st;
	logic             accept, out_free, load_out;
	logic             walk_oob, take_hit;

	unit_req_t ureq;
	unit_rsp_t ursp;

	// Write strobes and data for the channel storage at the current address.
	logic        sw_cnt_we, sw_st_we, al_cnt_we, al_lim_we, al_st_we;
	logic [31:0] sw_cnt_wd, al_cnt_wd, al_lim_wd;
	logic [1:0]  sw_st_wd, al_st_wd;

	satb_unit u_unit (
		.req(ureq),
		.rsp(ursp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_ok_q;

	assign sw_a     = idx_q[SW_IW-1:0];
	assign al_a     = idx_q[AL_IW-1:0];
	assign sw_valid = ({1'b0, ch_q} < SW_LIM);
	assign al_valid = ({1'b0, ch_q} < AL_LIM);
	assign sw_st    = sw_state_q[sw_a];
	assign al_st    = al_state_q[al_a];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, shared unit operands and storage writes.
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		res_ok_d   = res_ok_q;
		res_data_d = res_data_q;
		load_out   = 1'b0;
		ureq.op    = OP_INC;
		ureq.a     = val_q;
		ureq.b     = al_limit_q[al_a];
		sw_cnt_we  = 1'b0;
		sw_st_we   = 1'b0;
		al_cnt_we  = 1'b0;
		al_lim_we  = 1'b0;
		al_st_we   = 1'b0;
		sw_cnt_wd  = ursp.result;
		al_cnt_wd  = ursp.result;
		al_lim_wd  = val_q;
		sw_st_wd   = CS_COUNTING;
		al_st_wd   = CS_COUNTING;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// A tick visits every channel from zero; a command goes to its own.
					idx_d   = (s_tuser == FN_TICK) ? 4'd0 : s_tdata[3:0];
					state_d = (s_tuser == FN_TICK) ? ST_SW : ST_CMD;
				end
			end
			ST_SW: begin
				ureq.a    = sw_count_q[sw_a];
				sw_cnt_we = (sw_st == CS_COUNTING);
				if (idx_q == SW_LAST) begin
					idx_d   = 4'd0;
					state_d = ST_AL;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			ST_AL: begin
				ureq.a = al_count_q[al_a];
				if (al_st == CS_COUNTING) begin
					// A counting alarm finishes when it has reached its limit.
					al_st_we  = ursp.eq;
					al_st_wd  = CS_FINISHED;
					al_cnt_we = !ursp.eq;
				end
				if (idx_q == AL_LAST) begin
					res_ok_d   = 1'b1;
					res_data_d = 32'd0;
					state_d    = ST_DONE;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			ST_CMD: begin
				ureq.op    = OP_MUL100;
				ureq.a     = val_q;
				res_ok_d   = 1'b0;
				res_data_d = 32'd0;
				state_d    = ST_DONE;
				unique case (func_q)
					FN_SW_START: begin
						if (sw_valid && sw_st != CS_COUNTING) begin
							sw_cnt_we = 1'b1;
							sw_cnt_wd = 32'd0;
							sw_st_we  = 1'b1;
							res_ok_d  = 1'b1;
						end
					end
					FN_SW_SET: begin
						if (sw_valid) begin
							sw_st_we = 1'b1;
							sw_st_wd = val_q[1:0];
							res_ok_d = 1'b1;
						end
					end
					FN_SW_READ: begin
						if (sw_valid && sw_st != CS_COUNTING) begin
							res_data_d = sw_count_q[sw_a];
							res_ok_d   = 1'b1;
						end
					end
					FN_AL_START, FN_AL_MS: begin
						if (al_valid && al_st != CS_COUNTING) begin
							al_lim_we = 1'b1;
							al_lim_wd = (func_q == FN_AL_MS) ? ursp.result : val_q;
							al_cnt_we = 1'b1;
							al_cnt_wd = 32'd0;
							al_st_we  = 1'b1;
							res_ok_d  = 1'b1;
						end
					end
					FN_AL_READ: begin
						if (al_valid) begin
							res_data_d = {30'd0, al_st};
							res_ok_d   = 1'b1;
						end
					end
					FN_AL_SET: begin
						if (al_valid) begin
							al_st_we = 1'b1;
							al_st_wd = val_q[1:0];
							res_ok_d = 1'b1;
						end
					end
					FN_AL_TAKE: begin
						if (al_valid) begin
							res_ok_d = 1'b1;
							if (al_st == CS_FINISHED) begin
								al_st_we   = 1'b1;
								al_st_wd   = CS_IDLE;
								res_data_d = 32'd1;
							end
						end
					end
					default: begin
						// A tick never gets here; unknown codes report an error.
					end
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state and channel storage; the whole bank resets to idle and zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 4'd0;
			m_valid_q <= 1'b0;
			for (int k = 0; k < STOPWATCH_CHANNELS; k++) begin
				sw_count_q[k] <= 32'd0;
				sw_state_q[k] <= CS_IDLE;
			end
			for (int k = 0; k < ALARM_CHANNELS; k++) begin
				al_count_q[k] <= 32'd0;
				al_limit_q[k] <= 32'd0;
				al_state_q[k] <= CS_IDLE;
			end
		end else begin
			idx_q <= idx_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (sw_cnt_we) sw_count_q[sw_a] <= sw_cnt_wd;
			if (sw_st_we)  sw_state_q[sw_a] <= sw_st_wd;
			if (al_cnt_we) al_count_q[al_a] <= al_cnt_wd;
			if (al_lim_we) al_limit_q[al_a] <= al_lim_wd;
			if (al_st_we)  al_state_q[al_a] <= al_st_wd;
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			ch_q   <= s_tdata[3:0];
			val_q  <= s_tdata[35:4];
		end
		res_ok_q   <= res_ok_d;
		res_data_q <= res_data_d;
		if (load_out) begin
			m_ok_q   <= res_ok_q;
			m_data_q <= res_data_q;
		end
	end

	// Conditions watched by the assertions below.
	assign walk_oob = (state_q == ST_SW && idx_q > SW_LAST) ||
		(state_q == ST_AL && idx_q > AL_LAST);
	assign take_hit = (state_q == ST_CMD) && (func_q == FN_AL_TAKE) && al_valid &&
		(al_st == CS_FINISHED);

	// A result appears on the master side only as the sequencer hands it over.
	`ASSERT_CLK(a_out_from_done, clk, arst_n, $rose(m_tvalid) |-> $past(load_out), "stray result")
	// The tick walk never addresses a channel beyond either bank.
	`ASSERT_NEVER(a_walk_range, clk, arst_n, walk_oob, "tick walk out of range")
	// Taking a finished alarm leaves it idle.
	`ASSERT_CLK(a_take_clears, clk, arst_n, take_hit |=> (al_st == CS_IDLE), "taken alarm not idle")

endmodule
